FILE: hdl/ivws_pkg.sv
package ivws_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;
  localparam int DBL_W  = 128;

  // status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: hdl/ivws_div.sv
// 128-bit restoring divider, one quotient bit per cycle.
module ivws_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ivws_pkg::DBL_W-1:0]     num,
  input  logic [ivws_pkg::DBL_W-1:0]     den,
  output logic [ivws_pkg::DBL_W-1:0]     quo,
  output ivws_pkg::unit_stat_t           stat
);

  localparam int CW = $clog2(ivws_pkg::DBL_W);

  logic [ivws_pkg::DBL_W-1:0] nsh;
  logic [ivws_pkg::DBL_W-1:0] dv;
  logic [ivws_pkg::DBL_W-1:0] rem;
  logic [CW-1:0]              cnt;
  logic [ivws_pkg::DBL_W:0]   rem_sh;

  assign rem_sh = {rem, nsh[ivws_pkg::DBL_W-1]};

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      stat.busy <= 1'b0;
    end else if (start) begin
      nsh       <= num;
      dv        <= den;
      rem       <= '0;
      quo       <= '0;
      cnt       <= '0;
      stat.busy <= 1'b1;
    end else if (stat.busy) begin
      nsh <= {nsh[ivws_pkg::DBL_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dv}) begin
        rem <= ivws_pkg::DBL_W'(rem_sh - {1'b0, dv});
        quo <= {quo[ivws_pkg::DBL_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ivws_pkg::DBL_W-1:0];
        quo <= {quo[ivws_pkg::DBL_W-2:0], 1'b0};
      end
      cnt <= cnt + CW'(1);
      if (cnt == CW'(ivws_pkg::DBL_W - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ivws_sqrt.sv
// 128-bit integer square root, one result bit per cycle.
module ivws_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ivws_pkg::DBL_W-1:0]     rad,
  output logic [ivws_pkg::WIDE_W-1:0]    root,
  output ivws_pkg::unit_stat_t           stat
);

  localparam int CW = $clog2(ivws_pkg::WIDE_W);

  logic [ivws_pkg::DBL_W-1:0] rem;
  logic [ivws_pkg::DBL_W-1:0] res;
  logic [ivws_pkg::DBL_W-1:0] bitv;
  logic [ivws_pkg::DBL_W-1:0] trial;
  logic [CW-1:0]              cnt;

  assign trial = res + bitv;
  assign root  = res[ivws_pkg::WIDE_W-1:0];

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      stat.busy <= 1'b0;
    end else if (start) begin
      rem       <= rad;
      res       <= '0;
      bitv      <= ivws_pkg::DBL_W'(1) << (ivws_pkg::DBL_W - 2);
      cnt       <= '0;
      stat.busy <= 1'b1;
    end else if (stat.busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + CW'(1);
      if (cnt == CW'(ivws_pkg::WIDE_W - 1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

endmodule

FILE: hdl/inverse_variance_window_smoother_unit.sv
// Inverse-variance weighted moving average over histogram bins.
// Input channel: bin_valid/bin_stall carry one bin request (content, error,
// width, last_bin). Output channel: result_valid/result_stall carry one
// smoothed bin. Window is 2*HALF_WINDOW+1 bins, clipped at histogram ends;
// bins with zero error or width count for nothing. Results lag by
// HALF_WINDOW bins; the last bin flushes all pending results, the final one
// tagged last_result, and clears the window.
// Throughput: one bin at a time. A usable bin takes two multiplies and a
// divide for its weight and one more multiply for its error term; an
// unusable one takes none. Each result then takes two multiplies per usable
// window bin, then the content divide, square root and error divide. All
// divides share one 128-bit bit-serial divider. bin_stall is high
// from acceptance until the bin's results are all loaded into the output
// register and the window is updated, and while rst is high.
// Output register: a finished result waits there while result_stall is
// high; the next result is only computed on, and loaded when it frees.
// Reset (rst, synchronous) empties the window and drops any pending result.
module inverse_variance_window_smoother_unit #(
  parameter int HALF_WINDOW = 2,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        bin_valid,
  output logic        bin_stall,
  input  logic signed [31:0] bin_content,
  input  logic [31:0] bin_error,
  input  logic [31:0] bin_width,
  input  logic        last_bin,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [31:0] smoothed_content,
  output logic [31:0] smoothed_error,
  output logic        window_empty,
  output logic        last_result
);

  localparam int HIST = 2 * HALF_WINDOW;
  localparam int SPAN = HIST + 1;
  localparam int AW   = $clog2(SPAN);
  localparam int CW   = $clog2(HIST + 1);
  localparam int IW   = $clog2(3 * HALF_WINDOW + 2);
  localparam int NUM_SHIFT = 3 * FRAC_BITS + 32;
  localparam logic [IW-1:0] HW = IW'(HALF_WINDOW);
  localparam int DW = ivws_pkg::DBL_W;
  localparam int WW = ivws_pkg::WIDE_W;

  typedef enum logic [4:0] {
    IDLE, MUL, W_EEW, W_DIV, W_TERM, W_TSAT, STORE,
    SUM_INIT, SUM_K, SUM_C, SUM_T, RES_DIV1, DIV_WAIT, RES_SQRT,
    SQRT_WAIT, RES_FIN, EMIT, UPDATE
  } state_t;

  state_t state, mret, dret;

  // current bin
  logic [31:0] c_reg, e_reg, w_reg;
  logic        last_reg;
  logic [WW-1:0] weight;

  // window store: entries below cnt are history, entry cnt is the new bin
  logic [31:0]   hc [SPAN];
  logic [WW-1:0] hw [SPAN];
  logic [WW-1:0] ht [SPAN];
  logic [CW-1:0] cnt;

  logic [IW-1:0] p, k, win_first, win_last, lo_i, hi_i, mm;
  logic          win_any;
  logic [AW-1:0] ka;

  // sums
  logic [DW-1:0] sw, swc, st2;
  logic          neg_r, sneg;
  logic [31:0]   cont_r, err_r;
  logic          empty_r;

  // shared 32x32 multiplier, 64x64 product in four partial steps
  logic [WW-1:0] ma, mb, mprod;
  logic [1:0]    mpsh;
  logic [2:0]    mc;
  logic [DW-1:0] acc, mprod_sh;
  logic [31:0]   ma_part, mb_part;

  // divider and root
  logic          dstart, sstart;
  logic [DW-1:0] dnum, dden, dquo, srad;
  logic [WW-1:0] sroot;
  ivws_pkg::unit_stat_t dstat, sstat;

  // combinational helpers
  logic [WW-1:0] weight_sat, cmag;
  logic [DW-1:0] term_full, swc_mag;
  logic [DW:0]   st2_sum;
  logic [31:0]   cont_v;
  logic          emit_load;

  ivws_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .quo(dquo), .stat(dstat)
  );

  ivws_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sstart), .rad(srad),
    .root(sroot), .stat(sstat)
  );

  assign bin_stall = rst || (state != IDLE);
  assign ka        = k[AW-1:0];
  assign mm        = IW'(cnt) + IW'(1);
  // output register takes a result when empty or being drained this cycle
  assign emit_load = (state == EMIT) && (!result_valid || !result_stall);

  assign ma_part = mc[1] ? ma[63:32] : ma[31:0];
  assign mb_part = mc[0] ? mb[63:32] : mb[31:0];

  always_comb begin
    case (mpsh)
      2'd0:    mprod_sh = DW'(mprod);
      2'd1:    mprod_sh = DW'(mprod) << 32;
      default: mprod_sh = DW'(mprod) << 64;
    endcase
  end

  // window bounds
  always_comb begin
    win_any   = 1'b1;
    win_last  = mm - IW'(1);
    win_first = '0;
    if (last_reg) begin
      win_first = (mm > HW + IW'(1)) ? mm - IW'(1) - HW : '0;
    end else if (mm >= HW + IW'(1)) begin
      win_first = mm - IW'(1) - HW;
      win_last  = mm - IW'(1) - HW;
    end else begin
      win_any = 1'b0;
    end
    lo_i = (p >= HW) ? p - HW : '0;
    hi_i = (p + HW < mm) ? p + HW : mm - IW'(1);
  end

  always_comb begin
    weight_sat = (dquo[DW-1:WW] != '0) ? '1 :
                 (dquo[WW-1:0] == '0) ? WW'(1) : dquo[WW-1:0];
    term_full  = acc >> FRAC_BITS;
    cmag       = hc[ka][31] ? WW'(33'h1_0000_0000 - {1'b0, hc[ka]}) : WW'(hc[ka]);
    st2_sum    = {1'b0, st2} + {1'b0, acc};
    swc_mag    = swc[DW-1] ? DW'(0) - swc : swc;
    if (sneg) begin
      cont_v = (dquo[DW-1:32] != '0 || dquo[31:0] > 32'h8000_0000) ?
               32'h8000_0000 : dquo[31:0];
      cont_v = 32'(0) - cont_v;
    end else begin
      cont_v = (dquo[DW-1:31] != '0) ? 32'h7FFF_FFFF : dquo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    sstart <= 1'b0;
    if (rst) begin
      state        <= IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_load || (result_valid && result_stall);
      case (state)
        IDLE: begin
          if (bin_valid) begin
            c_reg    <= bin_content;
            e_reg    <= bin_error;
            w_reg    <= bin_width;
            last_reg <= last_bin;
            if (bin_error != '0 && bin_width != '0) begin
              ma    <= WW'(bin_error);
              mb    <= WW'(bin_error);
              mc    <= '0;
              acc   <= '0;
              mret  <= W_EEW;
              state <= MUL;
            end else begin
              weight <= '0;
              ht[cnt[AW-1:0]] <= '0;
              state  <= STORE;
            end
          end
        end
        MUL: begin
          if (mc != 3'd4) begin
            mprod <= WW'(ma_part) * WW'(mb_part);
            mpsh  <= 2'(mc[1]) + 2'(mc[0]);
          end
          if (mc != '0) begin
            acc <= acc + mprod_sh;
          end
          mc <= mc + 3'd1;
          if (mc == 3'd4) begin
            state <= mret;
          end
        end
        W_EEW: begin
          ma    <= acc[WW-1:0];
          mb    <= WW'(w_reg);
          mc    <= '0;
          acc   <= '0;
          mret  <= W_DIV;
          state <= MUL;
        end
        W_DIV: begin
          dnum   <= DW'(1) << NUM_SHIFT;
          dden   <= acc;
          dstart <= 1'b1;
          dret   <= W_TERM;
          state  <= DIV_WAIT;
        end
        W_TERM: begin
          weight <= weight_sat;
          ma     <= weight_sat;
          mb     <= WW'(e_reg);
          mc     <= '0;
          acc    <= '0;
          mret   <= W_TSAT;
          state  <= MUL;
        end
        W_TSAT: begin
          ht[cnt[AW-1:0]] <= (term_full[DW-1:WW] != '0) ? '1 : term_full[WW-1:0];
          state <= STORE;
        end
        STORE: begin
          hc[cnt[AW-1:0]] <= c_reg;
          hw[cnt[AW-1:0]] <= weight;
          p     <= win_first;
          state <= win_any ? SUM_INIT : UPDATE;
        end
        SUM_INIT: begin
          k     <= lo_i;
          sw    <= '0;
          swc   <= '0;
          st2   <= '0;
          state <= SUM_K;
        end
        SUM_K: begin
          if (k > hi_i) begin
            state <= RES_DIV1;
          end else if (hw[ka] == '0) begin
            k <= k + IW'(1);
          end else begin
            sw    <= sw + DW'(hw[ka]);
            neg_r <= hc[ka][31];
            ma    <= hw[ka];
            mb    <= cmag;
            mc    <= '0;
            acc   <= '0;
            mret  <= SUM_C;
            state <= MUL;
          end
        end
        SUM_C: begin
          swc   <= neg_r ? swc - acc : swc + acc;
          ma    <= ht[ka];
          mb    <= ht[ka];
          mc    <= '0;
          acc   <= '0;
          mret  <= SUM_T;
          state <= MUL;
        end
        SUM_T: begin
          st2   <= st2_sum[DW] ? '1 : st2_sum[DW-1:0];
          k     <= k + IW'(1);
          state <= SUM_K;
        end
        RES_DIV1: begin
          if (sw == '0) begin
            cont_r  <= '0;
            err_r   <= '0;
            empty_r <= 1'b1;
            state   <= EMIT;
          end else begin
            empty_r <= 1'b0;
            sneg    <= swc[DW-1];
            dnum    <= swc_mag;
            dden    <= sw;
            dstart  <= 1'b1;
            dret    <= RES_SQRT;
            state   <= DIV_WAIT;
          end
        end
        DIV_WAIT: begin
          if (dstat.done) begin
            state <= dret;
          end
        end
        RES_SQRT: begin
          cont_r <= cont_v;
          srad   <= st2;
          sstart <= 1'b1;
          state  <= SQRT_WAIT;
        end
        SQRT_WAIT: begin
          if (sstat.done) begin
            dnum   <= DW'(sroot) << FRAC_BITS;
            dden   <= sw;
            dstart <= 1'b1;
            dret   <= RES_FIN;
            state  <= DIV_WAIT;
          end
        end
        RES_FIN: begin
          err_r <= (dquo[DW-1:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];
          state <= EMIT;
        end
        EMIT: begin
          if (emit_load) begin
            smoothed_content <= cont_r;
            smoothed_error   <= err_r;
            window_empty     <= empty_r;
            last_result      <= last_reg && (p == mm - IW'(1));
            if (p == win_last) begin
              state <= UPDATE;
            end else begin
              p     <= p + IW'(1);
              state <= SUM_INIT;
            end
          end
        end
        UPDATE: begin
          if (last_reg) begin
            cnt <= '0;
          end else if (cnt < CW'(HIST)) begin
            cnt <= cnt + CW'(1);
          end else begin
            for (int i = 0; i < HIST; i++) begin
              hc[i] <= hc[i+1];
              hw[i] <= hw[i+1];
              ht[i] <= ht[i+1];
            end
          end
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // history never holds more than the window minus the center bin
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HIST))
    else $error("history count out of range");

  // an accepted bin keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    bin_valid && !bin_stall |=> bin_stall)
    else $error("input not stalled after accept");

  // an empty window always reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && window_empty |-> smoothed_content == '0 && smoothed_error == '0)
    else $error("empty window with nonzero result");

  // divider and root never run together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(dstat.busy && sstat.busy))
    else $error("divider and root busy together");

endmodule
